@@ rtl/md5_pkg.sv @@
// Shared types, constants and step functions for the MD5 digest block.
// Used by md5_core, md5_message_digest and md5_checker; depends on nothing.

package md5_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int STEP_W      = 6;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0]  PAD_MARK     = 8'h80;
   localparam logic [5:0]  LEN_FILL_MAX = 6'd56;
   localparam logic [5:0]  LAST_STEP    = 6'd63;
   localparam logic [5:0]  LAST_FILL    = 6'h3F;
   localparam logic [3:0]  LAST_WORD    = 4'd15;
   localparam logic [3:0]  LEN_LO_WORD  = 4'd14;
   localparam logic [1:0]  LAST_LANE    = 2'd3;

   localparam logic [31:0] STEP_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotation amounts, indexed by {round, step[1:0]}.
   localparam logic [4:0] ROT_AMT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } md5_req_type;

   typedef struct packed {
      logic [63:0] digest_first_half;
      logic [63:0] digest_second_half;
   } md5_rsp_type;

   typedef struct packed {
      logic start;   // load working words from the chain and run 64 steps
      logic init;    // return the chain to the initial words
   } md5_core_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMP,
      ST_PAD,
      ST_OUT
   } md5_state_type;

   // Message word used by a step.
   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [5:0] g;
      unique case (step[5:4])
         2'd0: g = step;
         2'd1: g = step * 6'd5 + 6'd1;
         2'd2: g = step * 6'd3 + 6'd5;
         2'd3: g = step * 6'd7;
      endcase
      return g[3:0];
   endfunction

   function automatic logic [31:0] round_fn(input logic [1:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      unique case (rnd)
         2'd0: f = (b & c) | (~b & d);
         2'd1: f = (d & b) | (~d & c);
         2'd2: f = b ^ c ^ d;
         2'd3: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

   function automatic logic [31:0] bswap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

@@ rtl/md5_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/md5_core.sv @@
// MD5 compression unit: one step per cycle over the 64 steps of a block,
// reading message words from the block RAM. Holds the chaining words.
// Depends on md5_pkg.

module md5_core import md5_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  md5_core_ctl_type ctl,
   output logic [3:0]       rd_addr,
   input  logic [31:0]      rd_data,
   output logic             done,
   output md5_rsp_type      digest
);

   logic        issue_act_ff, issue_act_in;
   logic [5:0]  issue_cnt_ff, issue_cnt_in;
   logic        s1_vld_ff;
   logic [5:0]  s1_idx_ff;
   logic        s2_vld_ff;
   logic [5:0]  s2_idx_ff;
   logic [31:0] km_ff, km_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic        fin_ff, fin_in;
   logic        done_ff;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] f_val;
   logic [31:0] t_val;
   logic [63:0] rot_dbl;

   // The address for each step goes out while the issue counter holds that step, the
   // word comes back in the next cycle and is summed with its constant, and the step itself runs after that.
   assign rd_addr = msg_index(issue_cnt_ff);

   always_comb begin
      issue_act_in = issue_act_ff;
      issue_cnt_in = issue_cnt_ff;
      if (ctl.start) begin
         issue_act_in = 1'b1;
         issue_cnt_in = '0;
      end else if (issue_act_ff) begin
         issue_cnt_in = issue_cnt_ff + 6'd1;
         if (issue_cnt_ff == LAST_STEP) begin
            issue_act_in = 1'b0;
         end
      end
   end

   assign km_in = rd_data + STEP_CONST[s1_idx_ff];

   always_comb begin
      f_val   = round_fn(s2_idx_ff[5:4], b_ff, c_ff, d_ff);
      t_val   = a_ff + f_val + km_ff;
      rot_dbl = {t_val, t_val} << ROT_AMT[{s2_idx_ff[5:4], s2_idx_ff[1:0]}];
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      if (ctl.start) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
      end else if (s2_vld_ff) begin
         a_in = d_ff;
         d_in = c_ff;
         c_in = b_ff;
         b_in = b_ff + rot_dbl[63:32];
      end
   end

   assign fin_in = s2_vld_ff && (s2_idx_ff == LAST_STEP);

   always_comb begin
      chain_in = chain_ff;
      if (ctl.init) begin
         chain_in[0] = INIT_A;
         chain_in[1] = INIT_B;
         chain_in[2] = INIT_C;
         chain_in[3] = INIT_D;
      end else if (fin_ff) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_act_ff <= 1'b0;
         issue_cnt_ff <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         done_ff      <= 1'b0;
         chain_ff[0]  <= INIT_A;
         chain_ff[1]  <= INIT_B;
         chain_ff[2]  <= INIT_C;
         chain_ff[3]  <= INIT_D;
      end else begin
         issue_act_ff <= issue_act_in;
         issue_cnt_ff <= issue_cnt_in;
         s1_vld_ff    <= issue_act_ff;
         s2_vld_ff    <= s1_vld_ff;
         fin_ff       <= fin_in;
         done_ff      <= fin_ff;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= issue_cnt_ff;
      s2_idx_ff <= s1_idx_ff;
      km_ff     <= km_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
   end

   assign done = done_ff;
   assign digest.digest_first_half  = {bswap32(chain_ff[0]), bswap32(chain_ff[1])};
   assign digest.digest_second_half = {bswap32(chain_ff[2]), bswap32(chain_ff[3])};

endmodule

@@ rtl/md5_message_digest.sv @@
// A byte request is accepted while idle; the 64th byte of a block holds off
// requests while the block is compressed.
// An end-of-message request pads, writing up to 16 words at one per cycle, and
// compresses once or twice before the digest appears. The compression unit
// runs one step per cycle.
// Reset is synchronous: initial chain words, zero count, no digest pending.
// Top level of the MD5 digest block: byte packing, padding sequencer, digest
// register. Depends on md5_pkg, md5_ram and md5_core.

module md5_message_digest import md5_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  md5_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output md5_rsp_type rsp_data
);

   md5_state_type    state_ff, state_in;
   logic [31:0]      acc_ff, acc_in;
   logic [63:0]      count_ff, count_in;
   logic [3:0]       ptr_ff, ptr_in;
   logic             fin_ff, fin_in;
   logic             padded_ff, padded_in;
   logic             second_ff, second_in;
   logic             lenw_ff, lenw_in;
   logic             rsp_valid_ff, rsp_valid_in;
   md5_rsp_type      rsp_data_ff, rsp_data_in;

   md5_core_ctl_type core_ctl;
   logic             core_done;
   md5_rsp_type      core_digest;
   logic [3:0]       rd_addr;
   logic [31:0]      rd_data;
   logic             wr_en;
   logic [3:0]       wr_addr;
   logic [31:0]      wr_data;

   logic             accept;
   logic [5:0]       fill;
   logic [63:0]      count_next;
   logic [31:0]      acc_new;
   logic [31:0]      pad_word;
   logic [63:0]      bit_len;
   logic             len_ok;

   md5_ram #(
      .WIDTH(WORD_W),
      .DEPTH(BLOCK_WORDS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   md5_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (core_ctl),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .done   (core_done),
      .digest (core_digest)
   );

   assign fill       = count_ff[5:0];
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign count_next = count_ff + 64'd1;
   assign bit_len    = {count_ff[60:0], 3'b000};
   assign len_ok     = (fill < LEN_FILL_MAX) || second_ff;

   always_comb begin
      acc_new = acc_ff;
      acc_new[fill[1:0]*8 +: 8] = req_data.data_byte;
   end

   // Bytes already in the open word stay, the marker follows, the rest is zero.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         if (j < fill[1:0]) begin
            pad_word[j*8 +: 8] = acc_ff[j*8 +: 8];
         end else if (j == fill[1:0]) begin
            pad_word[j*8 +: 8] = PAD_MARK;
         end else begin
            pad_word[j*8 +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      fin_in        = fin_ff;
      padded_in     = padded_ff;
      second_in     = second_ff;
      lenw_in       = lenw_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      core_ctl      = '0;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fin_in    = req_data.end_of_message;
               padded_in = 1'b0;
               second_in = 1'b0;
               lenw_in   = 1'b0;
               if (req_data.byte_present) begin
                  acc_in   = acc_new;
                  count_in = count_next;
                  if (fill[1:0] == LAST_LANE) begin
                     wr_en   = 1'b1;
                     wr_addr = fill[5:2];
                     wr_data = acc_new;
                  end
               end
               if (req_data.byte_present && (fill == LAST_FILL)) begin
                  core_ctl.start = 1'b1;
                  state_in       = ST_COMP;
               end else if (req_data.end_of_message) begin
                  ptr_in   = req_data.byte_present ? count_next[5:2] : fill[5:2];
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wr_en     = 1'b1;
            wr_addr   = ptr_ff;
            padded_in = 1'b1;
            ptr_in    = ptr_ff + 4'd1;
            if (!padded_ff) begin
               wr_data = pad_word;
            end else if (len_ok && (ptr_ff == LEN_LO_WORD)) begin
               wr_data = bit_len[31:0];
            end else if (len_ok && (ptr_ff == LAST_WORD)) begin
               wr_data = bit_len[63:32];
            end
            if (ptr_ff == LAST_WORD) begin
               lenw_in        = len_ok;
               core_ctl.start = 1'b1;
               state_in       = ST_COMP;
            end
         end
         ST_COMP: begin
            if (core_done) begin
               if (!fin_ff) begin
                  state_in = ST_IDLE;
               end else if (lenw_ff) begin
                  state_in = ST_OUT;
               end else begin
                  // Marker and zeros first; when the length did not fit, a
                  // second block of zeros carries it.
                  ptr_in    = padded_ff ? 4'd0 : fill[5:2];
                  second_in = padded_ff;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = core_digest;
               core_ctl.init = 1'b1;
               count_in      = '0;
               fin_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         fin_ff       <= 1'b0;
         padded_ff    <= 1'b0;
         second_ff    <= 1'b0;
         lenw_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         fin_ff       <= fin_in;
         padded_ff    <= padded_in;
         second_ff    <= second_in;
         lenw_ff      <= lenw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/md5_checker.sv @@
// Port-level checks for the MD5 digest block, bound to the top level.
// Depends on md5_pkg and md5_message_digest.

module md5_checker import md5_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input md5_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input md5_rsp_type rsp_data
);

   // A waiting digest is neither dropped nor changed.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("digest changed or dropped while stalled");

   // Closing a message keeps further requests out while padding runs.
   a_end_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.end_of_message |=> !req_ready)
      else $error("request taken right after an end of message");

   // A new digest only appears while requests are held off.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("digest appeared while idle");

   // After reset the block is idle with nothing to deliver.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind md5_message_digest md5_checker u_md5_checker (.*);

@@ dv/tb_md5_message_digest.sv @@
// Self-checking testbench for md5_message_digest: byte requests in, digests out.
// Depends on md5_pkg for the request and digest types; expected digests come
// from an MD5 predictor kept inside this file.

module tb_md5_message_digest;
   import md5_pkg::md5_req_type;
   import md5_pkg::md5_rsp_type;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam int          LENGTH_SLOT = 56;
   localparam int          RANDOM_ITEMS = 1950;
   localparam int          MIN_MESSAGES = 40;
   localparam int          DRAIN_CYCLES = 200;
   localparam int          LONG_HOLD_CYCLES = 500;
   localparam int          LONG_HOLD_AT = 5;

   localparam logic [31:0] SINE_ADD [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROT_LEFT [16] = '{
      7, 12, 17, 22,
      5,  9, 14, 20,
      4, 11, 16, 23,
      6, 10, 15, 21
   };

   typedef struct packed {
      logic [7:0]   data;
      logic         present;
      logic         eom;
      logic         known;
      logic [127:0] digest;
   } table_row_type;

   // Directed requests; rows with known digests: empty message, "a" and "abc".
   localparam table_row_type DIRECTED [14] = '{
      {8'h00, 1'b0, 1'b1, 1'b1, 128'hd41d8cd98f00b204e9800998ecf8427e},
      {8'h61, 1'b1, 1'b1, 1'b1, 128'h0cc175b9c0f1b6a831c399e269772661},
      {8'hff, 1'b0, 1'b0, 1'b0, 128'h0},
      {8'h61, 1'b1, 1'b0, 1'b0, 128'h0},
      {8'h5a, 1'b0, 1'b0, 1'b0, 128'h0},
      {8'h62, 1'b1, 1'b0, 1'b0, 128'h0},
      {8'h63, 1'b1, 1'b1, 1'b1, 128'h900150983cd24fb0d6963f7d28e17f72},
      {8'h00, 1'b1, 1'b0, 1'b0, 128'h0},
      {8'hff, 1'b1, 1'b0, 1'b0, 128'h0},
      {8'hff, 1'b0, 1'b1, 1'b0, 128'h0},
      {8'hff, 1'b1, 1'b1, 1'b0, 128'h0},
      {8'haa, 1'b1, 1'b0, 1'b0, 128'h0},
      {8'h55, 1'b1, 1'b1, 1'b0, 128'h0},
      {8'h3c, 1'b0, 1'b1, 1'b1, 128'hd41d8cd98f00b204e9800998ecf8427e}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   md5_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   md5_rsp_type rsp_data;

   logic [31:0] hash_state [4];
   logic [31:0] msg_words [16];
   logic [63:0] msg_len;

   md5_rsp_type pending_digests [$];
   int          mismatch_count = 0;
   int          messages_closed = 0;
   int          random_items = 0;
   bit          sender_burst = 1'b0;

   md5_message_digest uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic [31:0] byte_reverse(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   task automatic restart_chain();
      hash_state[0] = IV_A;
      hash_state[1] = IV_B;
      hash_state[2] = IV_C;
      hash_state[3] = IV_D;
      msg_len = 64'd0;
   endtask

   task automatic put_msg_byte(input int pos, input logic [7:0] v);
      int w;
      int sh;
      w  = (pos >> 2) & 15;
      sh = (pos & 3) * 8;
      msg_words[w][sh +: 8] = v;
   endtask

   task automatic absorb_block();
      logic [31:0] a, b, c, d, f, t;
      int g;
      int s;
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      for (int i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         t = a + f + SINE_ADD[i] + msg_words[g];
         s = ROT_LEFT[(i / 16) * 4 + (i % 4)];
         a = d;
         d = c;
         c = b;
         b = b + ((t << s) | (t >> (32 - s)));
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
   endtask

   // Advances the predicted state by one request; a closing request yields a digest.
   task automatic predict_digest(input md5_req_type r, output bit emits,
                                 output md5_rsp_type dg);
      int fill;
      logic [63:0] bit_len;
      emits = 1'b0;
      dg = '0;
      if (r.byte_present) begin
         fill = int'(msg_len[5:0]);
         put_msg_byte(fill, r.data_byte);
         msg_len = msg_len + 64'd1;
         if (fill == 63) absorb_block();
      end
      if (r.end_of_message) begin
         fill = int'(msg_len[5:0]);
         put_msg_byte(fill, PAD_BYTE);
         for (int p = fill + 1; p < 64; p++) put_msg_byte(p, 8'h00);
         // No room left for the length: it goes into an extra all-zero block.
         if (fill >= LENGTH_SLOT) begin
            absorb_block();
            foreach (msg_words[k]) msg_words[k] = '0;
         end
         bit_len = msg_len << 3;
         msg_words[14] = bit_len[31:0];
         msg_words[15] = bit_len[63:32];
         absorb_block();
         dg.digest_first_half  = {byte_reverse(hash_state[0]), byte_reverse(hash_state[1])};
         dg.digest_second_half = {byte_reverse(hash_state[2]), byte_reverse(hash_state[3])};
         emits = 1'b1;
         restart_chain();
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input md5_req_type r, input bit known,
                               input logic [127:0] known_digest);
      int gap;
      bit emits;
      md5_rsp_type dg;
      gap = sender_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_digest(r, emits, dg);
      if (emits) begin
         if (known) dg = known_digest;
         pending_digests.push_back(dg);
         messages_closed++;
      end
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      md5_req_type r;
      bit tail_bare;
      tail_bare = (len == 0) || ($urandom_range(0, 1) == 1);
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
         // Occasional request that carries neither a byte nor an end mark.
         if ($urandom_range(0, 15) == 0) begin
            r.data_byte      = 8'($urandom);
            r.byte_present   = 1'b0;
            r.end_of_message = 1'b0;
            send_request(r, 1'b0, '0);
         end
         r.data_byte      = 8'($urandom);
         r.byte_present   = 1'b1;
         r.end_of_message = !tail_bare && (k == len - 1);
         send_request(r, 1'b0, '0);
         random_items++;
      end
      if (tail_bare) begin
         r.data_byte      = 8'($urandom);
         r.byte_present   = 1'b0;
         r.end_of_message = 1'b1;
         send_request(r, 1'b0, '0);
         random_items++;
      end
   endtask

   initial begin : digest_receiver
      int gap;
      int received;
      md5_rsp_type want;
      rsp_ready = 1'b0;
      received = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (received == LONG_HOLD_AT) gap = LONG_HOLD_CYCLES;
         else if ($urandom_range(0, 3) == 0) gap = 0;
         else gap = $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         received++;
         if (pending_digests.size() == 0) begin
            report_mismatch($sformatf("digest %h_%h with no closed message",
                                      rsp_data.digest_first_half,
                                      rsp_data.digest_second_half));
         end else begin
            want = pending_digests.pop_front();
            if (rsp_data.digest_first_half !== want.digest_first_half)
               report_mismatch($sformatf("digest_first_half got %h expected %h",
                                         rsp_data.digest_first_half,
                                         want.digest_first_half));
            if (rsp_data.digest_second_half !== want.digest_second_half)
               report_mismatch($sformatf("digest_second_half got %h expected %h",
                                         rsp_data.digest_second_half,
                                         want.digest_second_half));
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      table_row_type row;
      md5_req_type r;
      int sel;
      int len;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      restart_chain();
      foreach (msg_words[k]) msg_words[k] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[n]) begin
         row = DIRECTED[n];
         r.data_byte      = row.data;
         r.byte_present   = row.present;
         r.end_of_message = row.eom;
         send_request(r, row.known, row.digest);
      end

      // Mostly short messages, with lengths around the block and padding boundaries.
      while (random_items < RANDOM_ITEMS || messages_closed < MIN_MESSAGES) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) len = $urandom_range(0, 8);
         else if (sel < 7) len = $urandom_range(52, 72);
         else if (sel < 9) len = $urandom_range(0, 140);
         else len = $urandom_range(120, 200);
         send_message(len);
      end
      req_valid <= 1'b0;

      while (pending_digests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_digests.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
